FILE: src/spq_pkg.sv
// spq_pkg: shared types and codes for the stable priority queue.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package spq_pkg;
   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_FIND   = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2,
      ST_RSVD      = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]  operation;
      logic [15:0] process_id;
      logic [7:0]  priority_req;
      logic [7:0]  proc_class;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] found_priority;
      logic [7:0] found_class;
      logic [3:0] found_position;
   } rsp_type;

   typedef struct packed {
      logic [15:0] id;
      logic [7:0]  prio;
      logic [7:0]  cls;
   } entry_type;

   localparam int ENTRY_W = 32;
   localparam int POS_W   = 4;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_INS,
      S_REM,
      S_DONE
   } fsm_type;
endpackage
`default_nettype wire

FILE: src/spq_ram.sv
// spq_ram: generic single-port-write, single-port-read RAM, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module spq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

FILE: src/stable_priority_queue_top.sv
// stable_priority_queue_top: sorted queue held in one RAM, walked by a sequencer.
// Depends on spq_pkg and spq_ram.
//
//   channel | ports                      | transfer
//   req     | start, busy, req_data      | start && !busy
//   rsp     | rsp_valid, rsp_data        | rsp_valid (one cycle, no stall)
//
// busy stays high while a request is worked: a scan reads one slot per cycle
// from the RAM (one read port, registered read), then insert or remove moves
// entries one per cycle. The result strobe follows, and the next transfer may
// land then.
// Reset empties the queue at once (fill count); no clearing pass.
// The receiver cannot stall; busy holds off the next item until the result.
`timescale 1ns / 1ps
`default_nettype none
module stable_priority_queue_top #(
   parameter int QUEUE_DEPTH = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire spq_pkg::req_type req_data,
   output logic                  rsp_valid,
   output spq_pkg::rsp_type      rsp_data
);
   import spq_pkg::*;

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   fsm_type         state_ff, state_in;
   req_type         req_ff, req_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [CW-1:0]   idx_ff, idx_in;       // scan index / move index
   logic            rvalid_ff, rvalid_in; // read in flight for slot idx_ff-1
   entry_type       hold_ff, hold_in;     // entry carried during insert shift
   rsp_type         rsp_ff, rsp_in;
   logic            rspv_ff, rspv_in;

   logic            wr_en;
   logic [AW-1:0]   wr_addr, rd_addr;
   entry_type       wr_data, rd_data;
   logic [CW-1:0]   prev;

   spq_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rspv_ff;
   assign rsp_data  = rsp_ff;
   assign prev      = idx_ff - CW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         rspv_ff   <= 1'b0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         rspv_ff   <= rspv_in;
         rvalid_ff <= rvalid_in;
      end
      req_ff  <= req_in;
      idx_ff  <= idx_in;
      hold_ff <= hold_in;
      rsp_ff  <= rsp_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (rvalid_ff) begin
               if (req_ff.operation == OP_INSERT) begin
                  if (rd_data.prio < req_ff.priority_req) begin
                     state_in = S_INS;
                  end else if (idx_ff >= count_ff) begin
                     state_in = S_INS;
                  end
               end else if (rd_data.id == req_ff.process_id) begin
                  state_in = (req_ff.operation == OP_REMOVE) ? S_REM : S_DONE;
               end else if (idx_ff >= count_ff) begin
                  state_in = S_DONE;
               end
            end else begin
               if (req_ff.operation == OP_NONE) begin
                  state_in = S_DONE;
               end else if (req_ff.operation == OP_INSERT) begin
                  if (count_ff == CW'(QUEUE_DEPTH)) begin
                     state_in = S_DONE;
                  end else if (count_ff == '0) begin
                     state_in = S_INS;
                  end
               end else if (count_ff == '0) begin
                  state_in = S_DONE;
               end
            end
         end
         S_INS: begin
            if (idx_ff > count_ff) begin
               state_in = S_DONE;
            end
         end
         S_REM: begin
            if (idx_ff >= count_ff) begin
               state_in = S_DONE;
            end
         end
         S_DONE:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      req_in    = req_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      rvalid_in = 1'b0;
      hold_in   = hold_ff;
      rsp_in    = rsp_ff;
      rspv_in   = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = prev[AW-1:0];
      wr_data   = hold_ff;
      rd_addr   = idx_ff[AW-1:0];
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in = req_data;
               idx_in = '0;
               rsp_in = '{status: ST_NOT_FOUND, default: '0};
            end
         end
         S_SCAN: begin
            // issue read of slot idx_ff while previous result checked
            if (rvalid_ff) begin
               if (req_ff.operation == OP_INSERT) begin
                  if (rd_data.prio < req_ff.priority_req) begin
                     // write new entry at prev, carry displaced one
                     wr_en   = 1'b1;
                     wr_addr = prev[AW-1:0];
                     wr_data = '{id: req_ff.process_id, prio: req_ff.priority_req,
                                 cls: req_ff.proc_class};
                     hold_in = rd_data;
                     rd_addr = idx_ff[AW-1:0];
                     idx_in  = idx_ff + CW'(1);
                     rvalid_in = (idx_ff < count_ff);
                  end else if (idx_ff >= count_ff) begin
                     // append at slot count
                     idx_in  = idx_ff + CW'(1);
                     hold_in = '{id: req_ff.process_id, prio: req_ff.priority_req,
                                 cls: req_ff.proc_class};
                  end else begin
                     idx_in    = idx_ff + CW'(1);
                     rvalid_in = 1'b1;
                  end
               end else if (rd_data.id == req_ff.process_id) begin
                  rsp_in.status = ST_OK;
                  if (req_ff.operation == OP_FIND) begin
                     rsp_in.found_priority = rd_data.prio;
                     rsp_in.found_class    = rd_data.cls;
                     rsp_in.found_position = (prev > CW'(15)) ? 4'hF : POS_W'(prev);
                  end
                  // remove: prev is the hole; read slot idx_ff next
                  rvalid_in = (idx_ff < count_ff);
                  idx_in    = idx_ff + CW'(1);
               end else if (idx_ff < count_ff) begin
                  idx_in    = idx_ff + CW'(1);
                  rvalid_in = 1'b1;
               end
            end else begin
               if (req_ff.operation == OP_INSERT && count_ff == CW'(QUEUE_DEPTH)) begin
                  rsp_in.status = ST_FULL;
               end else if (req_ff.operation == OP_INSERT && count_ff == '0) begin
                  idx_in  = CW'(1);
                  hold_in = '{id: req_ff.process_id, prio: req_ff.priority_req,
                              cls: req_ff.proc_class};
               end else if (req_ff.operation != OP_NONE && count_ff != '0) begin
                  idx_in    = CW'(1);
                  rvalid_in = 1'b1;
               end
            end
         end
         S_INS: begin
            // idx_ff-1 is the slot to fill with hold; read of idx_ff-1 issued before
            if (rvalid_ff) begin
               wr_en   = 1'b1;
               wr_addr = prev[AW-1:0];
               wr_data = hold_ff;
               hold_in = rd_data;
               idx_in  = idx_ff + CW'(1);
               rvalid_in = (idx_ff < count_ff);
            end else begin
               wr_en   = 1'b1;
               wr_addr = prev[AW-1:0];
               wr_data = hold_ff;
               idx_in  = idx_ff + CW'(2);
               count_in = count_ff + CW'(1);
               rsp_in.status = ST_OK;
            end
         end
         S_REM: begin
            // rd_data holds slot prev; write it to prev-1
            if (rvalid_ff) begin
               wr_en   = 1'b1;
               wr_addr = AW'(prev - CW'(1));
               wr_data = rd_data;
            end
            if (idx_ff < count_ff) begin
               idx_in    = idx_ff + CW'(1);
               rvalid_in = 1'b1;
            end else begin
               count_in = count_ff - CW'(1);
            end
         end
         S_DONE: begin
            rspv_in = 1'b1;
         end
         default: ;
      endcase
   end
endmodule
`default_nettype wire

FILE: test/tb.sv
// tb: self-checking bench for stable_priority_queue_top, predicting each
// response from a local model of the sorted queue. Depends on spq_pkg and the RTL.
`timescale 1ns / 1ps
module tb;
   import spq_pkg::*;

   localparam int DEPTH = 16;
   localparam int LIMIT = 2000000;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   req_type req_data = '0;
   logic rsp_valid;
   rsp_type rsp_data;

   stable_priority_queue_top #(.QUEUE_DEPTH(DEPTH)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   entry_type sorted_q[$];
   req_type pending_reqs[$];
   rsp_type expected_rsps[$];
   int mismatches = 0;
   int transfers = 0;
   int responses = 0;
   int cycles = 0;
   int gap_left = 0;
   bit quiet = 0;
   bit stim_done = 0;
   logic [15:0] id_pool[$];

   function automatic rsp_type queue_apply(req_type r);
      rsp_type o;
      int at;
      entry_type e;
      o = '0;
      o.status = ST_NOT_FOUND;
      at = -1;
      if (r.operation == OP_INSERT) begin
         if (sorted_q.size() >= DEPTH) o.status = ST_FULL;
         else begin
            at = 0;
            while (at < sorted_q.size() && sorted_q[at].prio >= r.priority_req) at++;
            e.id = r.process_id;
            e.prio = r.priority_req;
            e.cls = r.proc_class;
            sorted_q.insert(at, e);
            o.status = ST_OK;
         end
      end else if (r.operation == OP_REMOVE || r.operation == OP_FIND) begin
         foreach (sorted_q[i])
            if (at < 0 && sorted_q[i].id == r.process_id) at = i;
         if (at >= 0) begin
            o.status = ST_OK;
            if (r.operation == OP_REMOVE) sorted_q.delete(at);
            else begin
               o.found_priority = sorted_q[at].prio;
               o.found_class = sorted_q[at].cls;
               o.found_position = (at > 15) ? 4'd15 : at[3:0];
            end
         end
      end
      return o;
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && start && !busy) begin
         expected_rsps.push_back(queue_apply(req_data));
         transfers <= transfers + 1;
      end
      if (!reset && rsp_valid) begin
         responses <= responses + 1;
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("tb: response with nothing pending: %h", rsp_data);
         end else if (expected_rsps[0] !== rsp_data) begin
            mismatches++;
            if (mismatches <= 10)
               $display("tb: mismatch st %0d/%0d prio %0d/%0d cls %0d/%0d pos %0d/%0d",
                  expected_rsps[0].status, rsp_data.status,
                  expected_rsps[0].found_priority, rsp_data.found_priority,
                  expected_rsps[0].found_class, rsp_data.found_class,
                  expected_rsps[0].found_position, rsp_data.found_position);
            void'(expected_rsps.pop_front());
         end else void'(expected_rsps.pop_front());
      end
   end

   // driver: sample handshake state at the falling edge, then present next
   always @(negedge clock) begin
      if (!reset) begin
         if (start && busy) begin
            // hold the current item
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start <= 0;
         end else if (pending_reqs.size() > 0 && (quiet || $urandom_range(0, 9) != 0)) begin
            req_data <= pending_reqs.pop_front();
            start <= 1;
         end else begin
            start <= 0;
            if (!quiet && pending_reqs.size() > 0) gap_left <= $urandom_range(0, 12);
         end
      end
   end

   function automatic logic [15:0] pick_id();
      if (id_pool.size() > 0 && $urandom_range(0, 3) != 0)
         return id_pool[$urandom_range(0, id_pool.size() - 1)];
      return 16'($urandom_range(0, 65535));
   endfunction

   task automatic add_req(op_type op, logic [15:0] id, logic [7:0] p, logic [7:0] c);
      req_type r;
      r.operation = op;
      r.process_id = id;
      r.priority_req = p;
      r.proc_class = c;
      pending_reqs.push_back(r);
      if (op == OP_INSERT) id_pool.push_back(id);
   endtask

   initial begin
      int roll;
      int depth_bias;
      op_type op;
      add_req(OP_FIND, 16'h0000, 0, 0);
      add_req(OP_REMOVE, 16'hFFFF, 0, 0);
      add_req(OP_INSERT, 16'hFFFF, 8'hFF, 8'hFF);
      add_req(OP_INSERT, 16'h0000, 8'h00, 8'h00);
      add_req(OP_INSERT, 16'h1234, 8'h80, 8'h5A);
      add_req(OP_INSERT, 16'h5555, 8'h80, 8'hA5);
      add_req(OP_INSERT, 16'h1234, 8'h80, 8'h01);
      add_req(OP_FIND, 16'h1234, 8'hFF, 8'hFF);
      add_req(OP_NONE, 16'h1234, 8'h55, 8'hAA);
      add_req(OP_REMOVE, 16'h1234, 0, 0);
      add_req(OP_FIND, 16'h1234, 0, 0);
      add_req(OP_FIND, 16'h0000, 0, 0);
      for (int i = 0; i < 13; i++) add_req(OP_INSERT, 16'hAAAA, i[7:0], 8'hAA);
      add_req(OP_FIND, 16'h0000, 0, 0);
      add_req(OP_FIND, 16'hAAAA, 0, 0);
      for (int b = 0; b < 10; b++) begin
         depth_bias = $urandom_range(0, 2);
         for (int i = 0; i < 100; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 3) op = OP_NONE;
            else if (roll < 35 + depth_bias * 10) op = OP_INSERT;
            else if (roll < 65 + depth_bias * 5) op = OP_REMOVE;
            else op = OP_FIND;
            add_req(op, pick_id(), 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         end
         if (id_pool.size() > 64) id_pool = id_pool[id_pool.size() - 32:$];
      end
      for (int i = 0; i < 60; i++)
         add_req(op_type'($urandom_range(0, 2)), pick_id(), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)));
      stim_done = 1;
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 0;
      while (pending_reqs.size() >= 80) @(posedge clock);
      quiet = 1;
   end

   initial begin
      @(posedge clock);
      while (!(stim_done && !reset && pending_reqs.size() == 0 && !start &&
               expected_rsps.size() == 0)) @(posedge clock);
      repeat (2 * DEPTH + 20) @(posedge clock);
      $display("tb: %0d requests sent, %0d responses checked, %0d mismatches",
               transfers, responses, mismatches);
      if (mismatches == 0 && expected_rsps.size() == 0) $display("tb: done, clean");
      else $display("tb: done, errors");
      $finish;
   end

   initial begin
      wait (cycles >= LIMIT);
      $display("tb: timeout after %0d cycles", cycles);
      $display("tb: done, errors");
      $finish;
   end
endmodule
